// ===== design/xsrp_pkg.sv =====
// Shared widths, word types, register codes and the reciprocal table of the stripe read planner.
`timescale 1ns / 1ps
package xsrp_pkg;

	localparam int LVL_W    = 4;
	localparam int FIRST_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int PART_W   = 4;
	localparam int STRIPE_W = 10;
	localparam int START_W  = 10;
	localparam int LENGTH_W = 11;
	localparam int SLOT_W   = 11;

	// Block numbers inside a chunk, wide enough for any legal chunk size.
	localparam int DIV_W       = 12;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = DIV_W + RECIP_W;
	localparam int CFG_IDX_W   = 1;

	localparam int DEF_MAX_LEVEL        = 9;
	localparam int DEF_BLOCKS_PER_CHUNK = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRIPE_LEVEL = 1'b0,
		REG_LOST_PART    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [FIRST_W-1:0]  request_first;
		logic [COUNT_W-1:0]  request_count;
		logic [PART_W-1:0]   query_part;
		logic [STRIPE_W-1:0] query_stripe;
	} req_word_t;

	typedef struct packed {
		logic                fetch_parity;
		logic [START_W-1:0]  read_start;
		logic [LENGTH_W-1:0] read_length;
		logic                element_read;
		logic [SLOT_W-1:0]   buffer_slot;
		logic                needs_recovery;
		logic                request_error;
	} rsp_word_t;

	typedef struct packed {
		cfg_reg_t        index;
		logic [LVL_W-1:0] data;
	} cfg_word_t;

	// Rounded-up 2^16 / level. For dividends below 2^12 and levels up to 15 the
	// product shifted right by 16 is the exact quotient.
	function automatic logic [RECIP_W-1:0] xsrp_recip(input logic [LVL_W-1:0] lvl);
		logic [RECIP_W-1:0] r;
		case (lvl)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			4'd10:   r = 17'd6554;
			4'd11:   r = 17'd5958;
			4'd12:   r = 17'd5462;
			4'd13:   r = 17'd5042;
			4'd14:   r = 17'd4682;
			4'd15:   r = 17'd4370;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/xsrp_ifs.sv =====
// Valid/ready channel interfaces for the query, result and configuration words.
`timescale 1ns / 1ps
interface xsrp_req_if import xsrp_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface xsrp_rsp_if import xsrp_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface xsrp_cfg_if import xsrp_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/xor_stripe_read_planner.sv =====
// Top level of the XOR stripe read planner: a three-stage query pipeline.
`timescale 1ns / 1ps
// The planner answers one query word per clock cycle while rsp takes its
// results. A word accepted on req passes through three pipeline registers on
// its way to the result word on rsp: the first checks the request and
// multiplies the first and last block by a reciprocal of the stripe level,
// the second takes the stripe numbers and part positions out of those
// products, and the third works out the read range, the buffer slot and the
// recovery flag and is the output register. Each stage holds its word while
// the next one is full and stalled, so back pressure on rsp reaches req
// without losing or repeating a word. The stripe level and lost part are
// written through cfg, which is always ready; write them only while no query is in flight.
module xor_stripe_read_planner import xsrp_pkg::*; #(
	parameter int MAX_LEVEL        = DEF_MAX_LEVEL,
	parameter int BLOCKS_PER_CHUNK = DEF_BLOCKS_PER_CHUNK
) (
	input logic       clk,
	input logic       arst_n,
	xsrp_cfg_if.sink  cfg,
	xsrp_req_if.sink  req,
	xsrp_rsp_if.source rsp
);

	// Configuration registers.
	logic [LVL_W-1:0] stripe_level_q;
	logic [LVL_W-1:0] lost_part_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_level_q <= '0;
			lost_part_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				REG_STRIPE_LEVEL: stripe_level_q <= cfg.payload.data;
				REG_LOST_PART:    lost_part_q    <= cfg.payload.data;
			endcase
		end
	end

	// Stage handshake: a stage loads when it is empty or its word moves on.
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3     = !v_s3 || rsp.ready;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;
	assign rsp.valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: range check, effective level and lost part, reciprocal products.
	logic [DIV_W-1:0]   first_ext;
	logic [DIV_W-1:0]   blk_sum;
	logic [DIV_W-1:0]   blk_last;
	logic               err_c;
	logic [LVL_W-1:0]   lvl_c;
	logic [LVL_W-1:0]   lost_c;
	logic [RECIP_W-1:0] recip_c;

	always_comb begin
		first_ext = DIV_W'(req.payload.request_first);
		blk_sum   = first_ext + DIV_W'(req.payload.request_count);
		blk_last  = blk_sum - DIV_W'(1);
		err_c     = (req.payload.request_count == '0) ||
			((DIV_W + 1)'(blk_sum) > (DIV_W + 1)'(BLOCKS_PER_CHUNK));
		// A level beyond the supported maximum is clamped to it.
		lvl_c     = (int'(stripe_level_q) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : stripe_level_q;
		// A lost part past the level means nothing is missing.
		lost_c    = (lost_part_q > lvl_c) ? '0 : lost_part_q;
		recip_c   = xsrp_recip(lvl_c);
	end

	req_word_t         req_s1;
	logic [LVL_W-1:0]  lvl_s1, lost_s1;
	logic              err_s1, repl_s1;
	logic [DIV_W-1:0]  last_s1;
	logic [PROD_W-1:0] prodf_s1, prodl_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_s1   <= req.payload;
			lvl_s1   <= lvl_c;
			lost_s1  <= lost_c;
			err_s1   <= err_c;
			repl_s1  <= (stripe_level_q == '0);
			last_s1  <= blk_last;
			prodf_s1 <= PROD_W'(first_ext) * PROD_W'(recip_c);
			prodl_s1 <= PROD_W'(blk_last) * PROD_W'(recip_c);
		end
	end

	// Stage 2: first and last stripe, part positions inside them.
	logic [DIV_W-1:0]       fs_c, ls_c;
	logic [LVL_W-1:0]       remf_c, reml_c;
	logic [LVL_W:0]         pf_c, pl_c;
	logic                   many_c, frec_c, lrec_c;
	logic [LVL_W:0]         lost_ext_c;

	always_comb begin
		fs_c       = prodf_s1[RECIP_SHIFT +: DIV_W];
		ls_c       = prodl_s1[RECIP_SHIFT +: DIV_W];
		remf_c     = LVL_W'(DIV_W'(req_s1.request_first) -
			DIV_W'(fs_c * DIV_W'(lvl_s1)));
		reml_c     = LVL_W'(last_s1 - DIV_W'(ls_c * DIV_W'(lvl_s1)));
		pf_c       = (LVL_W + 1)'(remf_c) + (LVL_W + 1)'(1);
		pl_c       = (LVL_W + 1)'(reml_c) + (LVL_W + 1)'(1);
		many_c     = ls_c > fs_c;
		lost_ext_c = (LVL_W + 1)'(lost_s1);
		// The lost part must be rebuilt in an edge stripe if it is part of
		// the requested blocks there.
		frec_c     = (lost_s1 != '0) && (lost_ext_c >= pf_c) && (many_c || lost_ext_c <= pl_c);
		lrec_c     = (lost_s1 != '0) && (lost_ext_c <= pl_c) && (many_c || lost_ext_c >= pf_c);
	end

	req_word_t                  req_s2;
	logic [LVL_W-1:0]           lvl_s2, lost_s2;
	logic                       err_s2, repl_s2;
	logic [DIV_W-1:0]           last_s2, fs_s2, ls_s2;
	logic [LVL_W:0]             pf_s2, pl_s2;
	logic                       many_s2, frec_s2, lrec_s2;
	logic [STRIPE_W+LVL_W-1:0]  qlvl_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			req_s2  <= req_s1;
			lvl_s2  <= lvl_s1;
			lost_s2 <= lost_s1;
			err_s2  <= err_s1;
			repl_s2 <= repl_s1;
			last_s2 <= last_s1;
			fs_s2   <= fs_c;
			ls_s2   <= ls_c;
			pf_s2   <= pf_c;
			pl_s2   <= pl_c;
			many_s2 <= many_c;
			frec_s2 <= frec_c;
			lrec_s2 <= lrec_c;
			qlvl_s2 <= (STRIPE_W + LVL_W)'(req_s1.query_stripe) *
				(STRIPE_W + LVL_W)'(lvl_s1);
		end
	end

	// Stage 3: read range of the queried part, slot, recovery flag.
	localparam int SIZE_W = DIV_W + 2;

	logic [DIV_W-1:0]  q_c, first3_c, off_c, hi_c;
	logic [LVL_W:0]    p_c;
	logic              part_ok_c, fneed_c, lneed_c, size_pos_c, in_range_c;
	logic [SIZE_W-1:0] size_c;
	logic [SLOT_W-1:0] slot_c;
	rsp_word_t         rsp_c;

	always_comb begin
		q_c        = DIV_W'(req_s2.query_stripe);
		first3_c   = DIV_W'(req_s2.request_first);
		p_c        = (LVL_W + 1)'(req_s2.query_part);
		part_ok_c  = (req_s2.query_part != '0) && (req_s2.query_part <= lvl_s2);
		fneed_c    = ((p_c >= pf_s2) && (many_s2 || p_c <= pl_s2)) || frec_s2;
		lneed_c    = ((p_c <= pl_s2) && (many_s2 || p_c >= pf_s2)) || lrec_s2;
		// The edge stripes drop out of the range when neither the request nor
		// recovery needs this part there.
		size_c     = SIZE_W'(ls_s2) - SIZE_W'(fs_s2) + SIZE_W'(1) -
			SIZE_W'(!fneed_c) - SIZE_W'(!lneed_c);
		size_pos_c = !size_c[SIZE_W-1] && (size_c != '0);
		off_c      = fs_s2 + DIV_W'(!fneed_c);
		hi_c       = ls_s2 - DIV_W'(!lneed_c);
		in_range_c = (q_c >= off_c) && (q_c <= hi_c);

		// Blocks before the request in its first stripe go after the extras
		// of the last stripe; everything else sits at its block offset.
		if (q_c == fs_s2 && p_c < pf_s2) begin
			slot_c = SLOT_W'(req_s2.request_count) +
				(lrec_s2 ? SLOT_W'(lvl_s2) - SLOT_W'(pl_s2) : '0) +
				SLOT_W'(req_s2.query_part) - SLOT_W'(1);
		end else begin
			slot_c = SLOT_W'(qlvl_s2) + SLOT_W'(req_s2.query_part) - SLOT_W'(1) -
				SLOT_W'(req_s2.request_first);
		end

		rsp_c = '0;
		if (err_s2) begin
			rsp_c.request_error = 1'b1;
		end else if (repl_s2) begin
			// Replica: the request maps straight onto the copy's blocks.
			rsp_c.read_start  = START_W'(req_s2.request_first);
			rsp_c.read_length = LENGTH_W'(req_s2.request_count);
			if (q_c >= first3_c && q_c <= last_s2) begin
				rsp_c.element_read = 1'b1;
				rsp_c.buffer_slot  = SLOT_W'(q_c - first3_c);
			end
		end else begin
			rsp_c.needs_recovery = (lost_s2 != '0) && (q_c >= fs_s2) && (q_c <= ls_s2) &&
				!(q_c == fs_s2 && !frec_s2) && !(q_c == ls_s2 && !lrec_s2);
			if (part_ok_c) begin
				rsp_c.fetch_parity = (req_s2.query_part == lost_s2);
				if (size_pos_c) begin
					rsp_c.read_start  = START_W'(off_c);
					rsp_c.read_length = LENGTH_W'(size_c);
					if (in_range_c) begin
						rsp_c.element_read = 1'b1;
						rsp_c.buffer_slot  = slot_c;
					end
				end
			end
		end
	end

	rsp_word_t rsp_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rsp_s3 <= rsp_c;
		end
	end

	assign rsp.payload = rsp_s3;

endmodule
